>>> rtl/core/stable_merge_sorter_core_defines.svh
// Assertion macros shared by the sorter core modules.
`ifndef STABLE_MERGE_SORTER_CORE_DEFINES_SVH
`define STABLE_MERGE_SORTER_CORE_DEFINES_SVH

// Check that cons holds in every cycle in which ante holds, outside reset.
`define SMS_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond holds in every cycle outside reset.
`define SMS_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    `SMS_ASSERT_IMPLY(lbl, ck, rn, 1'b1, cond, msg)

`endif

>>> rtl/core/sms_pkg.sv
// Shared types and constants of the stable merge sorter core.
`default_nettype none

package sms_pkg;

    localparam int TAG_WIDTH   = 16;
    localparam int KEY_FIELD_W = 32;
    localparam int TDATA_WIDTH = 48;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } sms_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_PRIME,
        M_RUN
    } sms_mstate_t;

    // Top level to merge engine.
    typedef struct packed {
        logic start;
        logic signed_keys;
    } sms_ctl_t;

    // Merge engine to top level.
    typedef struct packed {
        logic done;
        logic src_sel;
    } sms_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/sms_bank.sv
// Entry memory bank: one write port, two registered read ports.
`default_nettype none

module sms_bank #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    output logic      [WIDTH-1:0]         rdata0,
    input  wire logic                     re1,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data while the port is not enabled.
    always_ff @(posedge clk)
    begin
        if (re0)
        begin
            rdata0 <= mem[raddr0];
        end
        if (re1)
        begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sms_merge.sv
// Bottom-up merge engine: ping-pongs runs between the two banks.
`default_nettype none
`include "stable_merge_sorter_core_defines.svh"

module sms_merge #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sms_pkg::sms_ctl_t              ctl,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0] n_in,
    input  wire logic [KEY_WIDTH+sms_pkg::TAG_WIDTH-1:0] rdata_a,
    input  wire logic [KEY_WIDTH+sms_pkg::TAG_WIDTH-1:0] rdata_b,
    output sms_pkg::sms_sts_t                   sts,
    output logic [$clog2(MAX_ENTRIES)-1:0]      raddr_a,
    output logic [$clog2(MAX_ENTRIES)-1:0]      raddr_b,
    output logic                                we,
    output logic [$clog2(MAX_ENTRIES)-1:0]      waddr,
    output logic [KEY_WIDTH+sms_pkg::TAG_WIDTH-1:0] wdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int SW = CW + 2;
    localparam int TW = sms_pkg::TAG_WIDTH;
    localparam int EW = KEY_WIDTH + TW;

    sms_pkg::sms_mstate_t state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [SW-1:0] w_reg, w_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] a_end_reg, a_end_next;
    logic [CW-1:0] b_end_reg, b_end_next;
    logic [CW-1:0] out_reg, out_next;
    logic          src_reg, src_next;
    logic          signed_reg, signed_next;
    logic          done_reg, done_next;

    logic [SW-1:0]        lw_sum;
    logic [SW-1:0]        l2w_sum;
    logic [SW-1:0]        w_dbl;
    logic [CW-1:0]        mid_pt;
    logic [CW-1:0]        stop_pt;
    logic                 a_ok;
    logic                 b_ok;
    logic [KEY_WIDTH-1:0] sign_flip;
    logic [KEY_WIDTH-1:0] ka;
    logic [KEY_WIDTH-1:0] kb;
    logic                 take_b;
    logic [CW-1:0]        a_nx;
    logic [CW-1:0]        b_nx;
    logic                 pair_end;

    // Run bounds of the pair that starts at lo.
    assign w_dbl   = w_reg << 1;
    assign lw_sum  = SW'(lo_reg) + w_reg;
    assign l2w_sum = SW'(lo_reg) + w_dbl;
    assign mid_pt  = (lw_sum < SW'(n_reg)) ? CW'(lw_sum) : n_reg;
    assign stop_pt = (l2w_sum < SW'(n_reg)) ? CW'(l2w_sum) : n_reg;

    // Flip the sign bit so that an unsigned compare gives the signed order.
    assign sign_flip = {signed_reg, {(KEY_WIDTH-1){1'b0}}};
    assign ka        = rdata_a[EW-1:TW] ^ sign_flip;
    assign kb        = rdata_b[EW-1:TW] ^ sign_flip;
    assign a_ok      = a_reg < a_end_reg;
    assign b_ok      = b_reg < b_end_reg;
    // Take the right run only on a strict greater-than to keep ties stable.
    assign take_b    = b_ok && (!a_ok || (ka > kb));
    assign a_nx      = a_reg + CW'(!take_b);
    assign b_nx      = b_reg + CW'(take_b);
    assign pair_end  = (out_reg + CW'(1)) == b_end_reg;

    assign we    = (state_reg == sms_pkg::M_RUN);
    assign waddr = out_reg[AW-1:0];
    assign wdata = take_b ? rdata_b : rdata_a;

    assign sts.done    = done_reg;
    assign sts.src_sel = src_reg;

    always_comb
    begin
        case (state_reg)
            sms_pkg::M_PRIME:
            begin
                raddr_a = lo_reg[AW-1:0];
                raddr_b = mid_pt[AW-1:0];
            end
            sms_pkg::M_RUN:
            begin
                raddr_a = a_nx[AW-1:0];
                raddr_b = b_nx[AW-1:0];
            end
            default:
            begin
                raddr_a = '0;
                raddr_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        lo_next     = lo_reg;
        w_next      = w_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        a_end_next  = a_end_reg;
        b_end_next  = b_end_reg;
        out_next    = out_reg;
        src_next    = src_reg;
        signed_next = signed_reg;
        done_next   = 1'b0;
        case (state_reg)
            sms_pkg::M_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next      = n_in;
                    signed_next = ctl.signed_keys;
                    src_next    = 1'b0;
                    lo_next     = '0;
                    w_next      = SW'(1);
                    if (n_in < CW'(2))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = sms_pkg::M_PRIME;
                    end
                end
            end
            sms_pkg::M_PRIME:
            begin
                a_next     = lo_reg;
                b_next     = mid_pt;
                a_end_next = mid_pt;
                b_end_next = stop_pt;
                out_next   = lo_reg;
                state_next = sms_pkg::M_RUN;
            end
            sms_pkg::M_RUN:
            begin
                a_next   = a_nx;
                b_next   = b_nx;
                out_next = out_reg + CW'(1);
                if (pair_end)
                begin
                    if (l2w_sum >= SW'(n_reg))
                    begin
                        // Pass over: swap banks and double the run length.
                        src_next = !src_reg;
                        lo_next  = '0;
                        w_next   = w_dbl;
                        if (w_dbl >= SW'(n_reg))
                        begin
                            done_next  = 1'b1;
                            state_next = sms_pkg::M_IDLE;
                        end
                        else
                        begin
                            state_next = sms_pkg::M_PRIME;
                        end
                    end
                    else
                    begin
                        lo_next    = CW'(l2w_sum);
                        state_next = sms_pkg::M_PRIME;
                    end
                end
            end
            default:
            begin
                state_next = sms_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sms_pkg::M_IDLE;
            src_reg    <= 1'b0;
            done_reg   <= 1'b0;
            w_reg      <= SW'(1);
            signed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            src_reg    <= src_next;
            done_reg   <= done_next;
            w_reg      <= w_next;
            signed_reg <= signed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        a_end_reg <= a_end_next;
        b_end_reg <= b_end_next;
        out_reg   <= out_next;
    end

    `SMS_ASSERT_ALWAYS(a_run_len_pow2, clk, rst_n, $onehot(w_reg), "run length not a power of two")
    `SMS_ASSERT_IMPLY(a_write_in_pair, clk, rst_n, state_reg == sms_pkg::M_RUN, (out_reg < b_end_reg) && (a_ok || b_ok), "merge write past pair end")

endmodule

`default_nettype wire

>>> rtl/core/stable_merge_sorter_core.sv
// Top level of the stable merge sorter: load, sort and emit control.
//
//   channel   direction  handshake                 contents
//   s_axis    in         s_axis_tvalid/tready      key, tag; tlast = last_item
//   m_axis    out        m_axis_tvalid/tready      sorted key, tag; tlast, tuser
//   cfg       in         cfg_we (no back-pressure) signed_keys
//
// Loading takes one request per cycle; each entry that fits is written to bank 0.
// A request with tlast starts the sort: ceil(log2 n) merge passes, each priming
// every run pair before merging it, as the engine reads two entries and writes
// one per cycle. Emitting then streams n results, one per cycle unless m_axis stalls.
// Input is stalled (s_axis_tready low) during sort and emit; no clearing pass
// is needed after reset, since only entries of the current set are read.
`default_nettype none
`include "stable_merge_sorter_core_defines.svh"

module stable_merge_sorter_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_axis_tdata: [31:0] key, [47:32] tag
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // m_axis_tdata: [31:0] sorted_key, [47:32] sorted_tag
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,
    output logic             m_axis_tlast,
    // m_axis_tuser: [0] overflowed
    output logic             m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int TW = sms_pkg::TAG_WIDTH;
    localparam int EW = KEY_WIDTH + TW;
    localparam int KF = sms_pkg::KEY_FIELD_W;

    sms_pkg::sms_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          signed_reg;
    logic          final_sel_reg, final_sel_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [KF-1:0] out_key_reg;
    logic [TW-1:0] out_tag_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    logic          in_accept;
    logic          store_ok;
    logic          load_we;
    logic          issue;
    logic          out_load;
    logic [EW-1:0] in_entry;
    logic [EW-1:0] emit_data;

    sms_pkg::sms_ctl_t mrg_ctl;
    sms_pkg::sms_sts_t mrg_sts;
    logic [AW-1:0] m_raddr_a;
    logic [AW-1:0] m_raddr_b;
    logic          m_we;
    logic [AW-1:0] m_waddr;
    logic [EW-1:0] m_wdata;
    logic [EW-1:0] m_rdata_a;
    logic [EW-1:0] m_rdata_b;

    logic          b0_we;
    logic [AW-1:0] b0_waddr;
    logic [EW-1:0] b0_wdata;
    logic          b1_we;
    logic          rd_en0;
    logic          rd_en1;
    logic [AW-1:0] rd_addr0;
    logic [EW-1:0] b0_rdata0;
    logic [EW-1:0] b0_rdata1;
    logic [EW-1:0] b1_rdata0;
    logic [EW-1:0] b1_rdata1;

    assign s_axis_tready = (state_reg == sms_pkg::ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign store_ok      = count_reg < CW'(MAX_ENTRIES);
    assign load_we       = in_accept && store_ok;
    // Keep only the low KEY_WIDTH bits of the key.
    assign in_entry      = {s_axis_tdata[KEY_WIDTH-1:0], s_axis_tdata[KF+TW-1:KF]};

    // Bank 0 takes loads and merge writes when bank 1 is the source.
    assign b0_we    = load_we || (m_we && mrg_sts.src_sel);
    assign b0_waddr = load_we ? count_reg[AW-1:0] : m_waddr;
    assign b0_wdata = load_we ? in_entry : m_wdata;
    assign b1_we    = m_we && !mrg_sts.src_sel;

    // Port 0 serves the emit stream outside of sorting.
    assign rd_en0   = (state_reg == sms_pkg::ST_SORT) || issue;
    assign rd_en1   = (state_reg == sms_pkg::ST_SORT);
    assign rd_addr0 = (state_reg == sms_pkg::ST_EMIT) ? emit_idx_reg[AW-1:0] : m_raddr_a;

    assign m_rdata_a = mrg_sts.src_sel ? b1_rdata0 : b0_rdata0;
    assign m_rdata_b = mrg_sts.src_sel ? b1_rdata1 : b0_rdata1;
    assign emit_data = final_sel_reg ? b1_rdata0 : b0_rdata0;

    assign mrg_ctl.start       = in_accept && s_axis_tlast;
    assign mrg_ctl.signed_keys = signed_reg;

    sms_bank #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (EW)
    ) u_bank0 (
        .clk    (clk),
        .we     (b0_we),
        .waddr  (b0_waddr),
        .wdata  (b0_wdata),
        .re0    (rd_en0),
        .raddr0 (rd_addr0),
        .rdata0 (b0_rdata0),
        .re1    (rd_en1),
        .raddr1 (m_raddr_b),
        .rdata1 (b0_rdata1)
    );

    sms_bank #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (EW)
    ) u_bank1 (
        .clk    (clk),
        .we     (b1_we),
        .waddr  (m_waddr),
        .wdata  (m_wdata),
        .re0    (rd_en0),
        .raddr0 (rd_addr0),
        .rdata0 (b1_rdata0),
        .re1    (rd_en1),
        .raddr1 (m_raddr_b),
        .rdata1 (b1_rdata1)
    );

    sms_merge #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mrg_ctl),
        .n_in    (count_next),
        .rdata_a (m_rdata_a),
        .rdata_b (m_rdata_b),
        .sts     (mrg_sts),
        .raddr_a (m_raddr_a),
        .raddr_b (m_raddr_b),
        .we      (m_we),
        .waddr   (m_waddr),
        .wdata   (m_wdata)
    );

    // Emit pipeline: memory read stage, then the output register.
    assign out_load = pend_reg && (!out_valid_reg || m_axis_tready);
    assign issue    = (state_reg == sms_pkg::ST_EMIT) && (emit_idx_reg < count_reg)
                      && (!pend_reg || out_load);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        final_sel_next = final_sel_reg;
        emit_idx_next  = emit_idx_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sms_pkg::ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_ok)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        // Drop the entry and flag the whole set.
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = sms_pkg::ST_SORT;
                    end
                end
            end
            sms_pkg::ST_SORT:
            begin
                if (mrg_sts.done)
                begin
                    final_sel_next = mrg_sts.src_sel;
                    emit_idx_next  = '0;
                    pend_next      = 1'b0;
                    state_next     = sms_pkg::ST_EMIT;
                end
            end
            sms_pkg::ST_EMIT:
            begin
                if (issue)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = (emit_idx_reg + CW'(1)) == count_reg;
                    emit_idx_next  = emit_idx_reg + CW'(1);
                end
                else if (out_load)
                begin
                    pend_next = 1'b0;
                end
                if ((emit_idx_reg == count_reg) && !pend_reg)
                begin
                    // Set fully handed to the output register: open for the next set.
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = sms_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sms_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sms_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            signed_reg    <= 1'b0;
            final_sel_reg <= 1'b0;
            emit_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            final_sel_reg <= final_sel_next;
            emit_idx_reg  <= emit_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                signed_reg <= cfg_wdata;
            end
        end
    end

    // Output payload: load from the read stage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_key_reg  <= KF'(emit_data[EW-1:TW]);
            out_tag_reg  <= emit_data[TW-1:0];
            out_last_reg <= pend_last_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tag_reg, out_key_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    `SMS_ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_reg <= CW'(MAX_ENTRIES), "entry count above capacity")
    `SMS_ASSERT_IMPLY(a_done_in_sort, clk, rst_n, mrg_sts.done, state_reg == sms_pkg::ST_SORT, "merge done outside sort")
    `SMS_ASSERT_IMPLY(a_emit_bound, clk, rst_n, state_reg == sms_pkg::ST_EMIT, (emit_idx_reg <= count_reg) && (count_reg != '0), "emit index past set size")
    `SMS_ASSERT_IMPLY(a_pend_in_emit, clk, rst_n, pend_reg, state_reg == sms_pkg::ST_EMIT, "read stage busy outside emit")

endmodule

`default_nettype wire
